// ===== rtl/cra_pkg.sv =====
package cra_pkg;

	// Operation codes of an input item.
	localparam logic [1:0] OP_REQUEST = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_COMPACT = 2'd2;
	localparam logic [1:0] OP_REPORT  = 2'd3;

	// Fit strategies.
	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_SPACE  = 3'd1;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
	localparam logic [2:0] ST_BAD_STRAT = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  owner_id;
		logic [31:0] request_size;
		logic [1:0]  strategy;
	} cra_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] region_start;
		logic [31:0] region_length;
		logic        region_in_use;
		logic [7:0]  region_owner;
		logic        last_result;
	} cra_out_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_RELEASE,
		S_MERGE,
		S_COMPACT,
		S_COMP_FIX,
		S_REPORT,
		S_OUT
	} cra_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic init;
		logic clr_idx;
		logic inc_idx;
		logic scan_step;
		logic split;
		logic commit_ok;
		logic set_fail;
		logic release_all;
		logic merge_step;
		logic compact_step;
		logic compact_fix;
		logic emit_report;
		logic emit_single;
	} cra_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic idx_end;
		logic found;
		logic need_split;
		logic table_full;
		logic bad_size;
		logic bad_strat;
		logic step_done;
		logic is_last;
	} cra_stat_t;

endpackage

// ===== rtl/cra_datapath.sv =====
module cra_datapath import cra_pkg::*; #(
	parameter int MaxRegions = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [31:0]                  mem_size,
	input  cra_in_t                      item,
	input  cra_cmd_t                     cmd,
	output cra_stat_t                    stat,
	output cra_out_t                     result
);
	localparam int IW = $clog2(MaxRegions);
	localparam int CW = $clog2(MaxRegions + 1);

	logic [31:0]  size_q  [MaxRegions];
	logic         used_q  [MaxRegions];
	logic [7:0]   owner_q [MaxRegions];
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [31:0]  addr_q;
	logic [31:0]  total_q;
	logic         found_q;
	logic [IW-1:0] pick_q;
	logic [31:0]  pick_addr_q;
	logic [31:0]  pick_size_q;

	logic [IW-1:0] idx;
	logic [IW-1:0] idx1;
	logic          take;
	logic          fits;

	assign idx  = idx_q[IW-1:0];
	assign idx1 = IW'(idx_q + CW'(1));

	// Candidate test for one scanned entry.
	always_comb begin
		fits = !used_q[idx] && (size_q[idx] >= item.request_size);
		take = 1'b0;
		if (fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (item.strategy == FIT_BEST) begin
				take = size_q[idx] < pick_size_q;
			end else if (item.strategy == FIT_WORST) begin
				take = size_q[idx] > pick_size_q;
			end
		end
	end

	always_comb begin
		stat.idx_end    = (idx_q >= count_q);
		stat.found      = found_q;
		stat.need_split = (pick_size_q > item.request_size);
		stat.table_full = (count_q >= CW'(MaxRegions));
		stat.bad_size   = (item.request_size == 32'd0);
		stat.bad_strat  = (item.strategy == 2'd3);
		stat.step_done  = (idx_q + CW'(1) >= count_q);
		stat.is_last    = (idx_q + CW'(1) == count_q);
	end

	// Control registers of the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(1);
			idx_q   <= '0;
			found_q <= 1'b0;
			for (int k = 0; k < MaxRegions; k++) used_q[k] <= 1'b0;
		end else begin
			if (cmd.init) begin
				count_q <= CW'(1);
				for (int k = 0; k < MaxRegions; k++) used_q[k] <= 1'b0;
			end
			if (cmd.clr_idx) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			if (cmd.inc_idx) idx_q <= idx_q + CW'(1);
			if (cmd.scan_step && take) found_q <= 1'b1;
			// Split shifts the tail up by one, inserting a free entry after the pick.
			if (cmd.split) begin
				for (int k = 1; k < MaxRegions; k++) begin
					if (IW'(k) > pick_q + IW'(1)) used_q[k] <= used_q[k-1];
					else if (IW'(k) == pick_q + IW'(1)) used_q[k] <= 1'b0;
				end
				count_q <= count_q + CW'(1);
			end
			if (cmd.commit_ok) used_q[pick_q] <= 1'b1;
			if (cmd.release_all) begin
				for (int k = 0; k < MaxRegions; k++)
					if (used_q[k] && owner_q[k] == item.owner_id) used_q[k] <= 1'b0;
			end
			// Merge of entry idx with idx+1, or remove of idx during compact.
			if ((cmd.merge_step && !used_q[idx] && !used_q[idx1]) ||
			    (cmd.compact_step && !used_q[idx])) begin
				for (int k = 0; k < MaxRegions - 1; k++) begin
					if (cmd.merge_step && IW'(k) > idx) used_q[k] <= used_q[k+1];
					if (cmd.compact_step && IW'(k) >= idx) used_q[k] <= used_q[k+1];
				end
				count_q <= count_q - CW'(1);
				if (cmd.inc_idx) idx_q <= idx_q;
			end
			if (cmd.compact_fix && used_q[0] && total_q != 32'd0 &&
			    count_q < CW'(MaxRegions)) begin
				for (int k = 2; k < MaxRegions; k++) used_q[k] <= used_q[k-1];
				used_q[1] <= 1'b0;
				count_q   <= count_q + CW'(1);
			end
		end
	end

	// Payload registers: sizes, owners, running sums and result.
	always_ff @(posedge clk) begin
		if (cmd.init) size_q[0] <= mem_size;
		if (cmd.clr_idx) begin
			addr_q  <= '0;
			total_q <= '0;
			pick_size_q <= '0;
			pick_q  <= '0;
			pick_addr_q <= '0;
		end
		if (cmd.scan_step) begin
			addr_q <= addr_q + size_q[idx];
			if (take) begin
				pick_q      <= idx;
				pick_addr_q <= addr_q;
				pick_size_q <= size_q[idx];
			end
		end
		if (cmd.split) begin
			for (int k = 1; k < MaxRegions; k++) begin
				if (IW'(k) > pick_q + IW'(1)) begin
					size_q[k]  <= size_q[k-1];
					owner_q[k] <= owner_q[k-1];
				end else if (IW'(k) == pick_q + IW'(1)) begin
					size_q[k] <= pick_size_q - item.request_size;
				end
			end
			size_q[pick_q] <= item.request_size;
		end
		if (cmd.commit_ok) owner_q[pick_q] <= item.owner_id;
		if (cmd.merge_step && !used_q[idx] && !used_q[idx1]) begin
			size_q[idx] <= size_q[idx] + size_q[idx1];
			for (int k = 0; k < MaxRegions - 1; k++) begin
				if (IW'(k) > idx) begin
					size_q[k]  <= size_q[k+1];
					owner_q[k] <= owner_q[k+1];
				end
			end
		end
		if (cmd.compact_step && !used_q[idx]) begin
			total_q <= total_q + size_q[idx];
			for (int k = 0; k < MaxRegions - 1; k++) begin
				if (IW'(k) >= idx) begin
					size_q[k]  <= size_q[k+1];
					owner_q[k] <= owner_q[k+1];
				end
			end
		end
		if (cmd.compact_fix) begin
			if (!used_q[0]) begin
				size_q[0] <= size_q[0] + total_q;
			end else if (total_q != 32'd0 && count_q < CW'(MaxRegions)) begin
				for (int k = 2; k < MaxRegions; k++) begin
					size_q[k]  <= size_q[k-1];
					owner_q[k] <= owner_q[k-1];
				end
				size_q[1] <= total_q;
			end
		end
		if (cmd.emit_report) begin
			addr_q <= addr_q + size_q[idx];
			result.status        <= ST_OK;
			result.region_start  <= addr_q;
			result.region_length <= size_q[idx];
			result.region_in_use <= used_q[idx];
			result.region_owner  <= used_q[idx] ? owner_q[idx] : 8'd0;
			result.last_result   <= (idx_q + CW'(1) == count_q);
		end
		if (cmd.emit_single) begin
			result <= '0;
			result.last_result <= 1'b1;
			if (cmd.commit_ok) begin
				result.region_start  <= pick_addr_q;
				result.region_length <= item.request_size;
				result.region_in_use <= 1'b1;
				result.region_owner  <= item.owner_id;
			end
		end
		if (cmd.set_fail) begin
			result <= '0;
			result.last_result <= 1'b1;
			if (stat.bad_size) result.status <= ST_BAD_SIZE;
			else if (stat.bad_strat) result.status <= ST_BAD_STRAT;
			else if (!found_q) result.status <= ST_NO_SPACE;
			else result.status <= ST_FULL;
		end
	end

endmodule

// ===== rtl/cra_ctrl.sv =====
module cra_ctrl import cra_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] op,
	input  logic       cfg_write,
	input  logic       out_stall,
	input  cra_stat_t  stat,
	output logic       in_take,
	output logic       out_valid,
	output cra_cmd_t   cmd
);
	cra_state_t state_q, state_d;
	logic       rep_q, rep_d;
	logic       boot_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rep_q   <= 1'b0;
			boot_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			rep_q   <= rep_d;
			boot_q  <= 1'b0;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		rep_d     = rep_q;
		cmd       = '0;
		in_take   = 1'b0;
		out_valid = 1'b0;
		// The table is rebuilt on a write and in the first cycle after reset.
		cmd.init  = cfg_write || boot_q;
		case (state_q)
			S_IDLE: begin
				in_take = 1'b1;
				if (in_valid) begin
					cmd.clr_idx = 1'b1;
					case (op)
						OP_REQUEST: state_d = S_SCAN;
						OP_RELEASE: state_d = S_RELEASE;
						OP_COMPACT: state_d = S_COMPACT;
						default:    state_d = S_REPORT;
					endcase
				end
			end
			S_SCAN: begin
				if (stat.bad_size || stat.bad_strat) begin
					cmd.set_fail = 1'b1;
					state_d = S_OUT;
				end else if (stat.idx_end) begin
					state_d = S_DECIDE;
				end else begin
					cmd.scan_step = 1'b1;
					cmd.inc_idx   = 1'b1;
				end
			end
			S_DECIDE: begin
				if (!stat.found || (stat.need_split && stat.table_full)) begin
					cmd.set_fail = 1'b1;
					state_d = S_OUT;
				end else if (stat.need_split) begin
					cmd.split = 1'b1;
					state_d = S_SHIFT;
				end else begin
					cmd.commit_ok   = 1'b1;
					cmd.emit_single = 1'b1;
					state_d = S_OUT;
				end
			end
			S_SHIFT: begin
				cmd.commit_ok   = 1'b1;
				cmd.emit_single = 1'b1;
				state_d = S_OUT;
			end
			S_RELEASE: begin
				cmd.release_all = 1'b1;
				state_d = S_MERGE;
			end
			S_MERGE: begin
				if (stat.step_done) begin
					cmd.emit_single = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.merge_step = 1'b1;
					cmd.inc_idx    = 1'b1;
				end
			end
			S_COMPACT: begin
				// Index 0 is never removed; start the sweep at entry one.
				if (stat.idx_end || stat.step_done) begin
					state_d = S_COMP_FIX;
				end else begin
					cmd.inc_idx = 1'b1;
					state_d = S_COMP_FIX;
					rep_d = 1'b1;
				end
				if (rep_q) begin
					cmd.inc_idx = 1'b0;
					if (stat.idx_end) begin
						state_d = S_COMP_FIX;
					end else begin
						cmd.compact_step = 1'b1;
						cmd.inc_idx      = 1'b1;
						state_d = S_COMPACT;
					end
				end else if (!(stat.idx_end || stat.step_done)) begin
					state_d = S_COMPACT;
				end
			end
			S_COMP_FIX: begin
				rep_d = 1'b0;
				cmd.compact_fix = 1'b1;
				cmd.emit_single = 1'b1;
				state_d = S_OUT;
			end
			S_REPORT: begin
				cmd.emit_report = 1'b1;
				cmd.inc_idx     = 1'b1;
				rep_d = stat.is_last;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (rep_q) begin
						rep_d = 1'b0;
						state_d = S_IDLE;
					end else if (!stat.idx_end && op == OP_REPORT) begin
						state_d = S_REPORT;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== rtl/contiguous_region_allocator_core.sv =====
// Contiguous region allocator.
// Input channel in_valid/in_stall carries an item (operation, owner, size,
// strategy); output channel out_valid/out_stall returns result items, each
// holding status, region start, length, use flag, owner and a last mark.
// Configuration channel cfg_valid/cfg_ready writes memory_size, which also
// rebuilds the table as one free region; write it only while idle.
// One item is worked at a time. A request scans the table one entry a cycle,
// a release merges one entry pair a cycle, a compact sweeps the table once,
// and a report emits one result per region. Results wait in an output
// register; while out_stall is high the result holds and no new item
// is taken.
// Reset gives a table with one free region of 1048576 units.
module contiguous_region_allocator_core import cra_pkg::*; #(
	parameter int MaxRegions = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic     in_valid,
	output logic     in_stall,
	input  cra_in_t  in_item,
	output logic     out_valid,
	input  logic     out_stall,
	output cra_out_t out_item
);
	logic [31:0] mem_size_q;
	cra_in_t     item_q;
	cra_cmd_t    cmd;
	cra_stat_t   stat;
	logic        in_take;
	logic        cfg_write;
	logic [1:0]  op_sel;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid;
	assign in_stall  = !in_take;

	// While idle the controller decodes the arriving item, later the held one.
	assign op_sel = in_take ? in_item.operation : item_q.operation;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q <= 32'd1048576;
		end else if (cfg_write) begin
			mem_size_q <= cfg_data;
		end
	end

	// Captured item.
	always_ff @(posedge clk) begin
		if (in_take && in_valid) item_q <= in_item;
	end

	cra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op_sel),
		.cfg_write (cfg_write),
		.out_stall (out_stall),
		.stat      (stat),
		.in_take   (in_take),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	cra_datapath #(.MaxRegions(MaxRegions)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.mem_size (cfg_write ? cfg_data : mem_size_q),
		.item     (item_q),
		.cmd      (cmd),
		.stat     (stat),
		.result   (out_item)
	);

endmodule

// ===== rtl/cra_checker.sv =====
module cra_checker import cra_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_stall,
	input logic     out_valid,
	input logic     out_stall,
	input cra_out_t out_item
);
	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_item))
		else $error("result changed under stall");

	// No item is taken while a result is shown.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("item taken while result pending");

	// An item taken is never answered in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("result too early");

	// A failed result carries no region.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_OK |->
		out_item.region_length == 32'd0 && out_item.last_result)
		else $error("failed result carries region");
endmodule

bind contiguous_region_allocator_core cra_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import cra_pkg::*;

	localparam int NREG = 16;
	localparam int WATCHDOG = 20000;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_stall;
	cra_in_t in_item;
	logic out_valid;
	logic out_stall;
	cra_out_t out_item;

	contiguous_region_allocator_core #(.MaxRegions(NREG)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	// Predicted region table.
	logic [31:0] tbl_size [NREG];
	logic        tbl_used [NREG];
	logic [7:0]  tbl_owner [NREG];
	int          tbl_count;
	logic [31:0] mem_size;

	cra_out_t expected_results [$];
	int mismatches;
	int idle_cycles;
	bit calm;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void table_rebuild();
		for (int k = 0; k < NREG; k++) begin
			tbl_size[k] = '0;
			tbl_used[k] = 1'b0;
			tbl_owner[k] = '0;
		end
		tbl_size[0] = mem_size;
		tbl_count = 1;
	endfunction

	function automatic void entry_remove(int i);
		for (int k = i; k + 1 < tbl_count; k++) begin
			tbl_size[k] = tbl_size[k + 1];
			tbl_used[k] = tbl_used[k + 1];
			tbl_owner[k] = tbl_owner[k + 1];
		end
		tbl_count--;
	endfunction

	function automatic void entry_insert(int i, logic [31:0] sz);
		for (int k = tbl_count; k > i; k--) begin
			tbl_size[k] = tbl_size[k - 1];
			tbl_used[k] = tbl_used[k - 1];
			tbl_owner[k] = tbl_owner[k - 1];
		end
		tbl_size[i] = sz;
		tbl_used[i] = 1'b0;
		tbl_owner[i] = '0;
		tbl_count++;
	endfunction

	function automatic cra_out_t plain_result(logic [2:0] st);
		cra_out_t r;
		r = '0;
		r.status = st;
		r.last_result = 1'b1;
		return r;
	endfunction

	// Applies one item to the predicted table and queues its results.
	function automatic void predict_allocator(cra_in_t it);
		cra_out_t r;
		logic [31:0] addr, pick_addr, total;
		int pick, i;
		bit found, take;
		logic [2:0] st;
		case (it.operation)
			OP_REQUEST: begin
				found = 1'b0; pick = 0; addr = '0; pick_addr = '0; st = ST_OK;
				if (it.request_size == 0) st = ST_BAD_SIZE;
				else if (it.strategy == 2'd3) st = ST_BAD_STRAT;
				else begin
					for (i = 0; i < tbl_count; i++) begin
						if (!tbl_used[i] && tbl_size[i] >= it.request_size) begin
							if (!found) take = 1'b1;
							else if (it.strategy == FIT_BEST) take = tbl_size[i] < tbl_size[pick];
							else if (it.strategy == FIT_WORST) take = tbl_size[i] > tbl_size[pick];
							else take = 1'b0;
							if (take) begin
								pick = i; pick_addr = addr; found = 1'b1;
							end
						end
						addr += tbl_size[i];
					end
					if (!found) st = ST_NO_SPACE;
					else if (tbl_size[pick] > it.request_size) begin
						if (tbl_count >= NREG) st = ST_FULL;
						else begin
							entry_insert(pick + 1, tbl_size[pick] - it.request_size);
							tbl_size[pick] = it.request_size;
						end
					end
				end
				if (st == ST_OK) begin
					tbl_used[pick] = 1'b1;
					tbl_owner[pick] = it.owner_id;
					r = plain_result(ST_OK);
					r.region_start = pick_addr;
					r.region_length = it.request_size;
					r.region_in_use = 1'b1;
					r.region_owner = it.owner_id;
				end else begin
					r = plain_result(st);
				end
				expected_results.push_back(r);
			end
			OP_RELEASE: begin
				for (i = 0; i < tbl_count; i++)
					if (tbl_used[i] && tbl_owner[i] == it.owner_id) begin
						tbl_used[i] = 1'b0;
						tbl_owner[i] = '0;
					end
				i = 0;
				while (i + 1 < tbl_count) begin
					if (!tbl_used[i] && !tbl_used[i + 1]) begin
						tbl_size[i] += tbl_size[i + 1];
						entry_remove(i + 1);
					end else begin
						i++;
					end
				end
				expected_results.push_back(plain_result(ST_OK));
			end
			OP_COMPACT: begin
				total = '0;
				i = 1;
				while (i < tbl_count) begin
					if (!tbl_used[i]) begin
						total += tbl_size[i];
						entry_remove(i);
					end else begin
						i++;
					end
				end
				if (!tbl_used[0]) tbl_size[0] += total;
				else if (total > 0 && tbl_count < NREG) entry_insert(1, total);
				expected_results.push_back(plain_result(ST_OK));
			end
			default: begin
				addr = '0;
				for (i = 0; i < tbl_count; i++) begin
					r = '0;
					r.status = ST_OK;
					r.region_start = addr;
					r.region_length = tbl_size[i];
					r.region_in_use = tbl_used[i];
					r.region_owner = tbl_used[i] ? tbl_owner[i] : 8'd0;
					r.last_result = (i + 1 == tbl_count);
					expected_results.push_back(r);
					addr += tbl_size[i];
				end
			end
		endcase
	endfunction

	function automatic bit coin_idle();
		return !calm && ($urandom_range(99) < 19);
	endfunction

	// Watchdog: cycles with no transfer on the input, output or configuration channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Receiver: random stall, compare every accepted result.
	always @(posedge clk) begin
		cra_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", out_item);
			end else begin
				want = expected_results.pop_front();
				if (out_item !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: st %0d/%0d start %h/%h len %h/%h use %b/%b own %h/%h last %b/%b",
							want.status, out_item.status, want.region_start,
							out_item.region_start, want.region_length,
							out_item.region_length, want.region_in_use,
							out_item.region_in_use, want.region_owner,
							out_item.region_owner, want.last_result,
							out_item.last_result);
				end
			end
		end
		out_stall <= arst_n ? coin_idle() : 1'b0;
	end

	// Valid stays high after an accept until the next call or an idle stretch
	// lowers it, so it gets one assignment per edge.
	task automatic send_item(cra_in_t it);
		while (coin_idle()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_allocator(it);
	endtask

	task automatic write_mem_size(logic [31:0] v);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mem_size = v;
		table_rebuild();
	endtask

	function automatic cra_in_t mk(logic [1:0] op, logic [7:0] own,
			logic [31:0] sz, logic [1:0] strat);
		cra_in_t it;
		it.operation = op;
		it.owner_id = own;
		it.request_size = sz;
		it.strategy = strat;
		return it;
	endfunction

	function automatic cra_in_t random_item(logic [31:0] msz);
		cra_in_t it;
		int p;
		p = $urandom_range(99);
		it.owner_id = 8'($urandom_range(7));
		if ($urandom_range(9) == 0) it.owner_id = 8'($urandom);
		it.strategy = 2'($urandom_range(2));
		if ($urandom_range(19) == 0) it.strategy = 2'd3;
		if (msz > 64) it.request_size = 32'($urandom_range(1, msz / 8));
		else it.request_size = 32'($urandom_range(1, 16));
		if ($urandom_range(29) == 0) it.request_size = 32'($urandom);
		if ($urandom_range(29) == 0) it.request_size = '0;
		if (p < 55) it.operation = OP_REQUEST;
		else if (p < 75) it.operation = OP_RELEASE;
		else if (p < 85) it.operation = OP_COMPACT;
		else it.operation = OP_REPORT;
		return it;
	endfunction

	// Directed rows; the expected result is filled in where obvious.
	cra_in_t dir_item [20];
	bit      dir_has [20];
	cra_out_t dir_want [20];

	initial begin
		logic [31:0] sizes [5];
		cra_out_t r;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		calm = 0;
		mem_size = 32'd1048576;
		table_rebuild();

		dir_item[0] = mk(OP_REPORT, 8'd0, 32'd0, FIT_FIRST);
		dir_item[1] = mk(OP_REQUEST, 8'd1, 32'd0, FIT_FIRST);
		dir_item[2] = mk(OP_REQUEST, 8'd1, 32'd5, 2'd3);
		dir_item[3] = mk(OP_REQUEST, 8'd1, 32'hFFFF_FFFF, FIT_WORST);
		dir_item[4] = mk(OP_REQUEST, 8'hFF, 32'd1000, FIT_FIRST);
		dir_item[5] = mk(OP_REQUEST, 8'd2, 32'd10, FIT_FIRST);
		dir_item[6] = mk(OP_REQUEST, 8'd3, 32'd500, FIT_BEST);
		dir_item[7] = mk(OP_RELEASE, 8'hFF, 32'd0, FIT_FIRST);
		dir_item[8] = mk(OP_REQUEST, 8'd4, 32'd20, FIT_BEST);
		dir_item[9] = mk(OP_REQUEST, 8'd5, 32'd30, FIT_WORST);
		dir_item[10] = mk(OP_REPORT, 8'd0, 32'd0, FIT_FIRST);
		dir_item[11] = mk(OP_RELEASE, 8'd99, 32'd0, FIT_FIRST);
		dir_item[12] = mk(OP_COMPACT, 8'd0, 32'd0, FIT_FIRST);
		dir_item[13] = mk(OP_REPORT, 8'd0, 32'd0, FIT_FIRST);
		dir_item[14] = mk(OP_RELEASE, 8'd2, 32'd0, FIT_FIRST);
		dir_item[15] = mk(OP_COMPACT, 8'd0, 32'd0, FIT_FIRST);
		dir_item[16] = mk(OP_REQUEST, 8'd6, 32'd1048576, FIT_FIRST);
		dir_item[17] = mk(OP_RELEASE, 8'd3, 32'd0, FIT_FIRST);
		dir_item[18] = mk(OP_RELEASE, 8'd4, 32'd0, FIT_FIRST);
		dir_item[19] = mk(OP_REPORT, 8'd0, 32'd0, FIT_FIRST);
		for (int k = 0; k < 20; k++) dir_has[k] = 0;
		r = plain_result(ST_OK);
		r.region_length = 32'd1048576;
		dir_has[0] = 1; dir_want[0] = r;
		dir_has[1] = 1; dir_want[1] = plain_result(ST_BAD_SIZE);
		dir_has[2] = 1; dir_want[2] = plain_result(ST_BAD_STRAT);
		dir_has[3] = 1; dir_want[3] = plain_result(ST_NO_SPACE);
		r = plain_result(ST_OK);
		r.region_length = 32'd1000;
		r.region_in_use = 1'b1;
		r.region_owner = 8'hFF;
		dir_has[4] = 1; dir_want[4] = r;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part; typed rows check the predictor, the receiver checks the block.
		for (int k = 0; k < 20; k++) begin
			send_item(dir_item[k]);
			if (dir_has[k] && expected_results[$] !== dir_want[k]) begin
				mismatches++;
				if (mismatches <= 10) $display("predictor row %0d disagrees", k);
			end
		end

		// Table-full case with a tiny memory and many one-unit requests.
		write_mem_size(32'd20);
		for (int k = 0; k < 16; k++) send_item(mk(OP_REQUEST, k[7:0], 32'd1, FIT_FIRST));
		send_item(mk(OP_REPORT, 8'd0, 32'd0, FIT_FIRST));
		send_item(mk(OP_RELEASE, 8'd15, 32'd0, FIT_FIRST));
		send_item(mk(OP_COMPACT, 8'd0, 32'd0, FIT_FIRST));

		// Zero memory size answers no space.
		write_mem_size(32'd0);
		send_item(mk(OP_REQUEST, 8'd1, 32'd1, FIT_FIRST));
		send_item(mk(OP_REPORT, 8'd0, 32'd0, FIT_FIRST));

		// Random phases over several memory sizes, the extremes among them.
		sizes[0] = 32'd1; sizes[1] = 32'd64; sizes[2] = 32'd1000;
		sizes[3] = 32'hFFFF_FFFF; sizes[4] = $urandom;
		for (int ph = 0; ph < 5; ph++) begin
			write_mem_size(sizes[ph]);
			calm = (ph == 2);
			for (int k = 0; k < 58; k++) send_item(random_item(sizes[ph]));
		end
		calm = 0;
		in_valid <= 1'b0;

		while (expected_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
